// File: src/aeps_pkg.sv
package aeps_pkg;

	// datapath operations issued by the sequencer
	typedef enum logic [4:0] {
		OP_NONE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_LOADPTS,
		OP_EMA_MUL,
		OP_EMA_WB,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV10,
		OP_SCORE_WB,
		OP_MEAN,
		OP_DEC_MUL,
		OP_DEC_WB,
		OP_INACT,
		OP_RISE_MUL,
		OP_RISE_WB,
		OP_ENH_MUL,
		OP_ENH_WB,
		OP_BDEC_MUL,
		OP_BDEC_WB,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic valid;
		logic flare;
		logic active;
		logic out_busy;
	} dp_sts_t;

	typedef struct packed {
		logic [15:0] alpha_a;
		logic [15:0] alpha_b;
		logic [15:0] turb_gain;
		logic [15:0] flare_gain;
	} cfg_t;

	// register indexes
	localparam logic [1:0] REG_ALPHA_A    = 2'd0;
	localparam logic [1:0] REG_ALPHA_B    = 2'd1;
	localparam logic [1:0] REG_TURB_GAIN  = 2'd2;
	localparam logic [1:0] REG_FLARE_GAIN = 2'd3;

	localparam logic [15:0] RST_ALPHA_A    = 16'd9830;
	localparam logic [15:0] RST_ALPHA_B    = 16'd7864;
	localparam logic [15:0] RST_TURB_GAIN  = 16'd4096;
	localparam logic [15:0] RST_FLARE_GAIN = 16'd2048;

	localparam logic [16:0] ONE_Q16      = 17'd65536;
	localparam logic [15:0] ALPHA_MIN    = 16'd3277;
	localparam logic [15:0] ALPHA_A_MAX  = 16'd26214;
	localparam logic [15:0] ALPHA_B_MAX  = 16'd22938;
	localparam logic [15:0] DECAY_Q16    = 16'd62259;
	localparam logic [15:0] RISE_Q16     = 16'd3277;
	localparam logic [16:0] INACT_LIMIT  = 17'd656;
	localparam logic [12:0] GAP_SAT      = 13'd4096;
	localparam logic [15:0] ENH_ONE      = 16'd16384;
	localparam logic [15:0] ENH_MAX      = 16'd32768;
	// level*20 > 4096 is level >= 205
	localparam logic [15:0] LEVEL_MIN    = 16'd205;
	// (2^23 + 2) / 10, exact floor(d/10) for d below 2^22
	localparam logic [21:0] RECIP10      = 22'd838861;
	localparam logic [32:0] FACTOR_ONE   = 33'd16777216;

	localparam logic [4:0] DIV_STEPS  = 5'd16;
	localparam logic [4:0] SQRT_STEPS = 5'd21;

endpackage

// File: src/aeps_ctrl.sv
module aeps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  aeps_pkg::dp_sts_t sts,
	output aeps_pkg::dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIV_INIT,
		S_DIV_STEP,
		S_DIV_END,
		S_BRANCH,
		S_LOADPTS,
		S_EMA_MUL,
		S_EMA_WB,
		S_SQ_X,
		S_SQ_Y,
		S_SQRT_INIT,
		S_SQRT_STEP,
		S_DIV10,
		S_SCORE_WB,
		S_MEAN,
		S_DEC_MUL,
		S_DEC_WB,
		S_INACT,
		S_FLARE,
		S_RISE_MUL,
		S_RISE_WB,
		S_ENH_MUL,
		S_ENH_WB,
		S_BDEC_MUL,
		S_BDEC_WB,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic [1:0] sel_q;
	logic       ready_q;
	logic       in_acc;

	assign s_tready = ready_q;
	assign in_acc   = s_tvalid & ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ready_q <= 1'b0;
						sel_q   <= 2'd0;
						state_q <= S_DIV_INIT;
					end
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == aeps_pkg::DIV_STEPS - 5'd1) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					if (sel_q == 2'd0) begin
						sel_q   <= 2'd1;
						state_q <= S_DIV_INIT;
					end else begin
						state_q <= S_BRANCH;
					end
				end
				S_BRANCH: begin
					sel_q <= 2'd0;
					if (sts.valid) begin
						state_q <= sts.active ? S_EMA_MUL : S_LOADPTS;
					end else if (sts.active) begin
						state_q <= S_DEC_MUL;
					end else begin
						state_q <= S_FLARE;
					end
				end
				S_LOADPTS: begin
					sel_q   <= 2'd0;
					state_q <= S_SQ_X;
				end
				S_EMA_MUL: state_q <= S_EMA_WB;
				S_EMA_WB: begin
					if (sel_q == 2'd3) begin
						sel_q   <= 2'd0;
						state_q <= S_SQ_X;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= S_EMA_MUL;
					end
				end
				S_SQ_X: state_q <= S_SQ_Y;
				S_SQ_Y: state_q <= S_SQRT_INIT;
				S_SQRT_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQRT_STEP;
				end
				S_SQRT_STEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == aeps_pkg::SQRT_STEPS - 5'd1) begin
						state_q <= S_DIV10;
					end
				end
				S_DIV10: state_q <= S_SCORE_WB;
				S_SCORE_WB: begin
					if (sel_q == 2'd1) begin
						state_q <= S_MEAN;
					end else begin
						sel_q   <= 2'd1;
						state_q <= S_SQ_X;
					end
				end
				S_MEAN: state_q <= S_FLARE;
				S_DEC_MUL: state_q <= S_DEC_WB;
				S_DEC_WB: begin
					if (sel_q == 2'd2) begin
						state_q <= S_INACT;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= S_DEC_MUL;
					end
				end
				S_INACT: state_q <= S_FLARE;
				S_FLARE: begin
					state_q <= (sts.flare && sts.active) ? S_RISE_MUL : S_BDEC_MUL;
				end
				S_RISE_MUL: state_q <= S_RISE_WB;
				S_RISE_WB:  state_q <= S_ENH_MUL;
				S_ENH_MUL:  state_q <= S_ENH_WB;
				S_ENH_WB:   state_q <= S_OUT;
				S_BDEC_MUL: state_q <= S_BDEC_WB;
				S_BDEC_WB:  state_q <= S_OUT;
				S_OUT: begin
					if (!sts.out_busy) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.idx = sel_q;
		case (state_q)
			S_DIV_INIT:  cmd.op = aeps_pkg::OP_DIV_INIT;
			S_DIV_STEP:  cmd.op = aeps_pkg::OP_DIV_STEP;
			S_DIV_END:   cmd.op = aeps_pkg::OP_DIV_END;
			S_LOADPTS:   cmd.op = aeps_pkg::OP_LOADPTS;
			S_EMA_MUL:   cmd.op = aeps_pkg::OP_EMA_MUL;
			S_EMA_WB:    cmd.op = aeps_pkg::OP_EMA_WB;
			S_SQ_X: begin
				cmd.op  = aeps_pkg::OP_SQ_X;
				cmd.idx = {sel_q[0], 1'b0};
			end
			S_SQ_Y: begin
				cmd.op  = aeps_pkg::OP_SQ_Y;
				cmd.idx = {sel_q[0], 1'b1};
			end
			S_SQRT_INIT: cmd.op = aeps_pkg::OP_SQRT_INIT;
			S_SQRT_STEP: cmd.op = aeps_pkg::OP_SQRT_STEP;
			S_DIV10:     cmd.op = aeps_pkg::OP_DIV10;
			S_SCORE_WB:  cmd.op = aeps_pkg::OP_SCORE_WB;
			S_MEAN:      cmd.op = aeps_pkg::OP_MEAN;
			S_DEC_MUL:   cmd.op = aeps_pkg::OP_DEC_MUL;
			S_DEC_WB:    cmd.op = aeps_pkg::OP_DEC_WB;
			S_INACT:     cmd.op = aeps_pkg::OP_INACT;
			S_RISE_MUL:  cmd.op = aeps_pkg::OP_RISE_MUL;
			S_RISE_WB:   cmd.op = aeps_pkg::OP_RISE_WB;
			S_ENH_MUL:   cmd.op = aeps_pkg::OP_ENH_MUL;
			S_ENH_WB:    cmd.op = aeps_pkg::OP_ENH_WB;
			S_BDEC_MUL:  cmd.op = aeps_pkg::OP_BDEC_MUL;
			S_BDEC_WB:   cmd.op = aeps_pkg::OP_BDEC_WB;
			S_OUT:       cmd.op = sts.out_busy ? aeps_pkg::OP_NONE : aeps_pkg::OP_OUT;
			default:     cmd.op = aeps_pkg::OP_NONE;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> state_q == S_IDLE)
		else $error("ready outside idle");
	a_sqrt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT_STEP |-> cnt_q < aeps_pkg::SQRT_STEPS)
		else $error("sqrt step count overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && sts.out_busy) |=> state_q == S_OUT)
		else $error("result dropped while output busy");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_DIV_INIT)
		else $error("request accepted without starting");
`endif

endmodule

// File: src/aeps_dp.sv
module aeps_dp #(
	parameter int COORD_BITS = 20,
	localparam int IN_W      = ((4 * COORD_BITS + 17 + 7) / 8) * 8,
	localparam int OUT_W     = ((4 * COORD_BITS + 84 + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_acc,
	input  logic [IN_W-1:0]          in_tdata,
	input  logic                     in_tuser,
	input  aeps_pkg::cfg_t           cfg,
	input  aeps_pkg::dp_cmd_t        cmd,
	output aeps_pkg::dp_sts_t        sts,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_W-1:0]         m_tdata,
	output logic                     m_tuser
);

	localparam int CB    = COORD_BITS;
	localparam int MW    = (CB + 1 > 22) ? CB + 1 : 22;
	localparam int PW    = MW + 22;

	logic                 valid_q;
	logic                 flare_q;
	logic [15:0]          level_q;
	logic signed [CB-1:0] raw_q    [4];
	logic signed [CB-1:0] smooth_q [4];
	logic [15:0]          alpha_q  [2];
	logic [32:0]          fac_q;
	logic [32:0]          rem_q;
	logic [15:0]          quo_q;
	logic [41:0]          rad_q;
	logic [22:0]          srem_q;
	logic [20:0]          root_q;
	logic [24:0]          sumx_q;
	logic signed [PW-1:0] prod_q;
	logic                 active_q;
	logic [16:0]          score_q  [3];
	logic [16:0]          blend_q;
	logic [15:0]          enh_q;
	logic                 mval_q;
	logic [OUT_W-1:0]     mdata_q;
	logic                 muser_q;

	logic signed [MW-1:0] ema_d;
	logic [MW-1:0]        gap_abs;
	logic [12:0]          gap_sat;
	logic signed [MW-1:0] ma;
	logic signed [21:0]   mb;
	logic [15:0]          base;
	logic [15:0]          alpha_sel;
	logic [33:0]          dv_t;
	logic                 dv_ge;
	logic [15:0]          dv_a;
	logic [15:0]          dv_max;
	logic [15:0]          dv_clamp;
	logic [24:0]          sq_t;
	logic [22:0]          sq_trial;
	logic                 sq_ge;
	logic [24:0]          sq_diff;
	logic [17:0]          pen;
	logic [17:0]          pen_sat;
	logic signed [PW-1:0] ema_acc;
	logic signed [PW-1:0] ema_new;
	logic [16:0]          rise_inc;
	logic [17:0]          blend_nx;
	logic [19:0]          enh_nx;

	assign sts.valid    = valid_q;
	assign sts.flare    = flare_q;
	assign sts.active   = active_q;
	assign sts.out_busy = mval_q;

	assign m_tvalid = mval_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;

	always_comb begin
		ema_d     = MW'(raw_q[cmd.idx]) - MW'(smooth_q[cmd.idx]);
		gap_abs   = ema_d[MW-1] ? MW'(-ema_d) : MW'(ema_d);
		gap_sat   = (gap_abs > MW'(aeps_pkg::GAP_SAT)) ? aeps_pkg::GAP_SAT : gap_abs[12:0];
		alpha_sel = alpha_q[cmd.idx[1]];
		base      = cmd.idx[0] ? cfg.alpha_b : cfg.alpha_a;

		dv_t     = {rem_q, 1'b0};
		dv_ge    = dv_t >= {1'b0, fac_q};
		dv_a     = (level_q >= aeps_pkg::LEVEL_MIN) ? quo_q : base;
		dv_max   = cmd.idx[0] ? aeps_pkg::ALPHA_B_MAX : aeps_pkg::ALPHA_A_MAX;
		dv_clamp = (dv_a < aeps_pkg::ALPHA_MIN) ? aeps_pkg::ALPHA_MIN :
			(dv_a > dv_max) ? dv_max : dv_a;

		sq_t     = {srem_q, rad_q[41:40]};
		sq_trial = {root_q, 2'b01};
		sq_ge    = sq_t >= {2'b00, sq_trial};
		sq_diff  = sq_t - {2'b00, sq_trial};

		pen      = prod_q[40:23];
		pen_sat  = (pen > 18'(aeps_pkg::ONE_Q16)) ? 18'(aeps_pkg::ONE_Q16) : pen;

		ema_acc  = (PW'(smooth_q[cmd.idx]) <<< 16) + prod_q + PW'(32768);
		ema_new  = ema_acc >>> 16;

		rise_inc = 17'((prod_q[32:0] + 33'd32768) >> 16);
		blend_nx = 18'(blend_q) + 18'(rise_inc);
		enh_nx   = 20'(aeps_pkg::ENH_ONE) + 20'((prod_q[33:0] + 34'd8192) >> 14);

		case (cmd.op)
			aeps_pkg::OP_EMA_MUL: begin
				ma = ema_d;
				mb = 22'(alpha_sel);
			end
			aeps_pkg::OP_SQ_X, aeps_pkg::OP_SQ_Y: begin
				ma = MW'(gap_sat);
				mb = 22'(gap_sat);
			end
			aeps_pkg::OP_DIV10: begin
				ma = MW'(root_q);
				mb = aeps_pkg::RECIP10;
			end
			aeps_pkg::OP_DEC_MUL: begin
				ma = MW'(score_q[cmd.idx]);
				mb = 22'(aeps_pkg::DECAY_Q16);
			end
			aeps_pkg::OP_RISE_MUL: begin
				ma = MW'(aeps_pkg::ONE_Q16 - blend_q);
				mb = 22'(aeps_pkg::RISE_Q16);
			end
			aeps_pkg::OP_ENH_MUL: begin
				ma = MW'(blend_q);
				mb = 22'(cfg.flare_gain);
			end
			aeps_pkg::OP_BDEC_MUL: begin
				ma = MW'(blend_q);
				mb = 22'(aeps_pkg::DECAY_Q16);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			valid_q <= in_tuser;
			for (int i = 0; i < 4; i++) begin
				raw_q[i] <= in_tdata[i*CB +: CB];
			end
			flare_q <= in_tdata[4*CB];
			level_q <= in_tdata[4*CB+1 +: 16];
		end
		prod_q <= PW'(ma * mb);
		case (cmd.op)
			aeps_pkg::OP_DIV_INIT: begin
				fac_q <= aeps_pkg::FACTOR_ONE + 33'(level_q) * 33'(cfg.turb_gain);
				rem_q <= 33'(base) << 8;
				quo_q <= '0;
			end
			aeps_pkg::OP_DIV_STEP: begin
				rem_q <= dv_ge ? 33'(dv_t - {1'b0, fac_q}) : dv_t[32:0];
				quo_q <= {quo_q[14:0], dv_ge};
			end
			aeps_pkg::OP_DIV_END: alpha_q[cmd.idx[0]] <= dv_clamp;
			aeps_pkg::OP_SQ_Y: sumx_q <= prod_q[24:0];
			aeps_pkg::OP_SQRT_INIT: begin
				rad_q  <= {26'(sumx_q) + 26'(prod_q[24:0]), 16'd0};
				srem_q <= '0;
				root_q <= '0;
			end
			aeps_pkg::OP_SQRT_STEP: begin
				srem_q <= sq_ge ? sq_diff[22:0] : sq_t[22:0];
				root_q <= {root_q[19:0], sq_ge};
				rad_q  <= rad_q << 2;
			end
			aeps_pkg::OP_ENH_WB: begin
				enh_q <= (enh_nx > 20'(aeps_pkg::ENH_MAX)) ? aeps_pkg::ENH_MAX : enh_nx[15:0];
			end
			aeps_pkg::OP_BDEC_WB: enh_q <= aeps_pkg::ENH_ONE;
			aeps_pkg::OP_OUT: begin
				mdata_q <= OUT_W'({enh_q, blend_q, score_q[2], score_q[1], score_q[0],
					smooth_q[3], smooth_q[2], smooth_q[1], smooth_q[0]});
				muser_q <= active_q;
			end
			default: ;
		endcase
	end

	// tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				smooth_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				score_q[i] <= '0;
			end
			blend_q <= '0;
			mval_q  <= 1'b0;
		end else begin
			if (cmd.op == aeps_pkg::OP_OUT) begin
				mval_q <= 1'b1;
			end else if (m_tready) begin
				mval_q <= 1'b0;
			end
			case (cmd.op)
				aeps_pkg::OP_LOADPTS: begin
					for (int i = 0; i < 4; i++) begin
						smooth_q[i] <= raw_q[i];
					end
					active_q <= 1'b1;
				end
				aeps_pkg::OP_EMA_WB: smooth_q[cmd.idx] <= ema_new[CB-1:0];
				aeps_pkg::OP_SCORE_WB: begin
					score_q[cmd.idx[0]] <= 17'(18'(aeps_pkg::ONE_Q16) - pen_sat);
				end
				aeps_pkg::OP_MEAN: begin
					score_q[2] <= 17'((18'(score_q[0]) + 18'(score_q[1])) >> 1);
				end
				aeps_pkg::OP_DEC_WB: score_q[cmd.idx] <= prod_q[32:16];
				aeps_pkg::OP_INACT: begin
					if (score_q[0] < aeps_pkg::INACT_LIMIT) begin
						active_q <= 1'b0;
					end
				end
				aeps_pkg::OP_RISE_WB: begin
					blend_q <= (blend_nx > 18'(aeps_pkg::ONE_Q16)) ? aeps_pkg::ONE_Q16 :
						blend_nx[16:0];
				end
				aeps_pkg::OP_BDEC_WB: blend_q <= prod_q[32:16];
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		score_q[2] <= aeps_pkg::ONE_Q16)
		else $error("mean score above one");
	a_blend_range: assert property (@(posedge clk) disable iff (!arst_n)
		blend_q <= aeps_pkg::ONE_Q16)
		else $error("blend above one");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == aeps_pkg::OP_OUT |-> !mval_q)
		else $error("output register overwritten");
`endif

endmodule

// File: src/adaptive_ema_point_stabilizer.sv
// Two-point stabilizer with turbulence-adapted exponential smoothing.
// Input stream: one request per frame. s_tuser carries frame_valid, s_tdata
// the raw points, flare flag and turbulence level. Output stream: one result
// per request; m_tuser carries tracking_active, m_tdata the smoothed points,
// stability scores, flare blend and enhancement factor.
// An APB port holds four 16-bit registers at byte offsets 0, 4, 8, 12:
// point a base alpha, point b base alpha, turbulence gain, flare gain.
// Write them only while the block is idle.
// An invalid frame goes straight to the flare update when not tracking, and
// first decays the scores and checks inactivity while tracking. A valid frame
// loads the points when not tracking, else smooths them, then scores both.
// The flare update raises the blend when flare is on while tracking, else
// decays it. Two 16-step alpha divisions share one restoring divider, each
// stability score takes a 21-step square root, and the other arithmetic
// shares one registered multiplier. s_tready returns only as the result
// enters the output register. Reset clears tracking, smoothed points, scores and blend,
// and loads the register defaults. When the receiver stalls the result waits
// in the output register; the next request is taken and processed but its
// result is held back until the waiting one leaves.
module adaptive_ema_point_stabilizer #(
	parameter int COORD_BITS = 20,
	localparam int IN_W      = ((4 * COORD_BITS + 17 + 7) / 8) * 8,
	localparam int OUT_W     = ((4 * COORD_BITS + 84 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// a_x, a_y, b_x, b_y, flare_on, turbulence_level
	input  logic [IN_W-1:0]        s_tdata,
	// frame_valid
	input  logic [0:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// smooth_a_x, smooth_a_y, smooth_b_x, smooth_b_y, stability_a,
	// stability_b, stability_mean, blend_level, enhancement
	output logic [OUT_W-1:0]       m_tdata,
	// tracking_active
	output logic [0:0]             m_tuser,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	aeps_pkg::cfg_t    cfg_q;
	aeps_pkg::dp_cmd_t cmd;
	aeps_pkg::dp_sts_t sts;
	logic              in_acc;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign in_acc  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_a    <= aeps_pkg::RST_ALPHA_A;
			cfg_q.alpha_b    <= aeps_pkg::RST_ALPHA_B;
			cfg_q.turb_gain  <= aeps_pkg::RST_TURB_GAIN;
			cfg_q.flare_gain <= aeps_pkg::RST_FLARE_GAIN;
		end else if (wr_en) begin
			case (reg_idx)
				aeps_pkg::REG_ALPHA_A:    cfg_q.alpha_a    <= pwdata[15:0];
				aeps_pkg::REG_ALPHA_B:    cfg_q.alpha_b    <= pwdata[15:0];
				aeps_pkg::REG_TURB_GAIN:  cfg_q.turb_gain  <= pwdata[15:0];
				aeps_pkg::REG_FLARE_GAIN: cfg_q.flare_gain <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			aeps_pkg::REG_ALPHA_A:    prdata = 32'(cfg_q.alpha_a);
			aeps_pkg::REG_ALPHA_B:    prdata = 32'(cfg_q.alpha_b);
			aeps_pkg::REG_TURB_GAIN:  prdata = 32'(cfg_q.turb_gain);
			aeps_pkg::REG_FLARE_GAIN: prdata = 32'(cfg_q.flare_gain);
			default:                  prdata = '0;
		endcase
	end

	aeps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aeps_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.in_tdata (s_tdata),
		.in_tuser (s_tuser[0]),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser[0])
	);

endmodule
